FILE: hw/rtl/bitmap_set_clear_find_next_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap set/clear/find-next block
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SET_CLEAR_FIND_NEXT_ASSERT_SVH
`define BITMAP_SET_CLEAR_FIND_NEXT_ASSERT_SVH

// Same-cycle implication
`define BSCFN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BSCFN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bscfn_pkg.sv
// ----------------------------------------------------------------------------
// bscfn_pkg
// Sizes, operation codes and stream layout of the bitmap block.
// ----------------------------------------------------------------------------
package bscfn_pkg;

  // Bitmap size
  localparam int unsigned NBITS = 256;
  localparam int unsigned IdxW  = (NBITS > 1) ? $clog2(NBITS) : 1;
  localparam int unsigned PopW  = $clog2(NBITS + 1);

  // Field widths on the streams
  localparam int unsigned FuncW    = 3;
  localparam int unsigned BitIdxW  = 10;
  localparam int unsigned PopOutW  = 11;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  // Operation codes
  typedef enum logic [FuncW-1:0] {
    FuncSet      = 3'd0,
    FuncClear    = 3'd1,
    FuncTest     = 3'd2,
    FuncFindNext = 3'd3,
    FuncClearAll = 3'd4
  } func_e;

endpackage

FILE: hw/rtl/bitmap_set_clear_find_next.sv
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_next
// Bitmap with set, clear, test, find-next-set and clear-all requests.
// ----------------------------------------------------------------------------
// One request is taken per clock while the output is not stalled, and each
// produces one result. A request is held in an input register; once the
// result slot is free, the bitmap is updated and the result is formed from
// the updated bitmap and registered. That step holds a priority encoder over
// the masked bitmap for find-next; the population is a running counter
// adjusted by each set or clear. An index at or beyond the bitmap size flags
// out_of_range and leaves the bitmap unchanged. Clear-all ignores the index.
// Codes 5 to 7 behave as a test.
// ----------------------------------------------------------------------------
module bitmap_set_clear_find_next (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] func, [12:3] bit_index, [15:13] zero
  input  logic [bscfn_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] bit_value, [1] next_found, [11:2] next_index, [22:12] population,
  // [23] is_empty, [24] out_of_range, [31:25] zero
  output logic [bscfn_pkg::OutDataW-1:0]  m_axis_tdata
);
  import bscfn_pkg::*;

  // Input register
  logic               in_valid_q;
  logic [FuncW-1:0]   func_q;
  logic [BitIdxW-1:0] idx_q;

  // State
  logic [NBITS-1:0]   bitmap_q, bitmap_d;
  logic [PopW-1:0]    pop_q, pop_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic               res_bit_q, res_found_q, res_empty_q, res_oor_q;
  logic [BitIdxW-1:0] res_next_q;
  logic [PopOutW-1:0] res_pop_q;

  logic               advance;
  logic               in_range;
  logic [IdxW-1:0]    idx_lo;
  logic               is_clear_all;
  logic               cur_bit;
  logic [NBITS-1:0]   masked;
  logic               found;
  logic [IdxW-1:0]    next_at;

  // Lowest set bit of a vector
  function automatic logic [IdxW-1:0] lowest_set(input logic [NBITS-1:0] v);
    logic [IdxW-1:0] pos;
    pos = '0;
    for (int k = NBITS - 1; k >= 0; k--) begin
      if (v[k]) begin
        pos = IdxW'(k);
      end
    end
    return pos;
  endfunction

  // Handshake: the held request moves on when the result slot is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);

  // Request decode
  assign in_range     = ({1'b0, idx_q} < (BitIdxW + 1)'(NBITS));
  assign idx_lo       = idx_q[IdxW-1:0];
  assign is_clear_all = (func_e'(func_q) == FuncClearAll);
  assign cur_bit      = bitmap_q[idx_lo];

  // Bitmap and population update
  always_comb begin
    bitmap_d = bitmap_q;
    pop_d    = pop_q;
    if (advance) begin
      if (is_clear_all) begin
        bitmap_d = '0;
        pop_d    = '0;
      end else if (in_range) begin
        case (func_e'(func_q))
          FuncSet: begin
            bitmap_d[idx_lo] = 1'b1;
            if (!cur_bit) begin
              pop_d = pop_q + PopW'(1);
            end
          end
          FuncClear: begin
            bitmap_d[idx_lo] = 1'b0;
            if (cur_bit) begin
              pop_d = pop_q - PopW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Find-next over the updated bitmap
  assign masked  = bitmap_d & ({NBITS{1'b1}} << idx_lo);
  assign found   = in_range && !is_clear_all && (|masked);
  assign next_at = lowest_set(masked);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      bitmap_q    <= '0;
      pop_q       <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
      bitmap_q    <= bitmap_d;
      pop_q       <= pop_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      func_q <= s_axis_tdata[FuncW-1:0];
      idx_q  <= s_axis_tdata[FuncW+BitIdxW-1:FuncW];
    end
    if (advance) begin
      res_bit_q   <= in_range && !is_clear_all && bitmap_d[idx_lo];
      res_found_q <= found;
      res_next_q  <= found ? BitIdxW'(next_at) : '0;
      res_pop_q   <= PopOutW'(pop_d);
      res_empty_q <= (pop_d == '0);
      res_oor_q   <= !in_range && !is_clear_all;
    end
  end

  // Output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, res_oor_q, res_empty_q, res_pop_q, res_next_q,
                          res_found_q, res_bit_q};

  // Checks
`include "bitmap_set_clear_find_next_assert.svh"

  `BSCFN_ASSERT_IMP(a_pop_matches, 1'b1, pop_q == PopW'($countones(bitmap_q)), "population counter out of step with bitmap")
  `BSCFN_ASSERT_IMP(a_oor_quiet, out_valid_q && res_oor_q, !res_found_q && !res_bit_q && (res_next_q == '0), "out-of-range result carries lookup data")
  `BSCFN_ASSERT_IMP(a_hold_on_stall, out_valid_q && !m_axis_tready, !advance, "result overwritten while stalled")
  `BSCFN_ASSERT_NXT(a_clear_all, advance && is_clear_all, (bitmap_q == '0) && (pop_q == '0), "clear-all left bits set")

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for bitmap_set_clear_find_next. A queue of requests feeds a
// clocked driver; directed corner cases come first, then random traffic. A
// bitmap predictor runs on each input transaction. A clocked monitor checks
// every output transaction field by field against the oldest predicted reply.
// Both sides idle at random, and once the receiver holds off long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb;
  import bscfn_pkg::*;

  localparam int unsigned RandomReqs  = 1200;
  localparam int unsigned HoldAt      = 250;   // replies seen before the long hold
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PadW        = InDataW - FuncW - BitIdxW;

  typedef struct packed {
    logic [FuncW-1:0]   func;
    logic [BitIdxW-1:0] idx;
  } bitmap_req_t;

  typedef struct packed {
    logic               bit_value;
    logic               next_found;
    logic [BitIdxW-1:0] next_index;
    logic [PopOutW-1:0] population;
    logic               is_empty;
    logic               out_of_range;
  } bitmap_reply_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  bitmap_req_t   request_queue[$];
  bitmap_reply_t bitmap_replies[$];
  logic [NBITS-1:0] model_bits = '0;

  bitmap_req_t   cur_req;
  bitmap_reply_t seen_reply;
  bitmap_reply_t due_reply;
  int unsigned   n_requests = 0;
  int unsigned   accepted   = 0;
  int unsigned   delivered  = 0;
  int unsigned   tx_gap     = 0;
  int unsigned   rx_gap     = 0;
  bit            tx_calm    = 1'b0;
  bit            rx_calm    = 1'b0;
  bit            held_off   = 1'b0;
  int unsigned   errors     = 0;

  bitmap_set_clear_find_next u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bitmap predictor: applies one request and returns the reply it causes
  function automatic bitmap_reply_t predict_reply(input bitmap_req_t r);
    bitmap_reply_t e;
    logic          in_range;
    int            k;
    e        = '0;
    in_range = (r.idx < NBITS);
    if (r.func == FuncClearAll) begin
      model_bits = '0;
    end else if (!in_range) begin
      e.out_of_range = 1'b1;
    end else if (r.func == FuncSet) begin
      model_bits[r.idx] = 1'b1;
    end else if (r.func == FuncClear) begin
      model_bits[r.idx] = 1'b0;
    end
    // Bit value and find-next come from the bitmap after the update
    if (in_range && !e.out_of_range) begin
      e.bit_value = model_bits[r.idx];
      for (k = int'(r.idx); k < int'(NBITS); k++) begin
        if (model_bits[k]) begin
          e.next_found = 1'b1;
          e.next_index = BitIdxW'(k);
          break;
        end
      end
    end
    e.population = PopOutW'($countones(model_bits));
    e.is_empty   = (model_bits == '0);
    return e;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len(input bit calm);
    int unsigned p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void add_req(input logic [FuncW-1:0] f, input int unsigned i);
    bitmap_req_t r;
    r.func = f;
    r.idx  = BitIdxW'(i);
    request_queue.push_back(r);
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: offers queued requests, predicts on each input transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bitmap_replies.push_back(predict_reply(cur_req));
        accepted++;
        if (accepted % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        tx_gap = idle_len(tx_calm);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          cur_req = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {PadW'(0), cur_req.idx, cur_req.func};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each output transaction, paces tready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_reply.bit_value    = m_axis_tdata[0];
        seen_reply.next_found   = m_axis_tdata[1];
        seen_reply.next_index   = m_axis_tdata[11:2];
        seen_reply.population   = m_axis_tdata[22:12];
        seen_reply.is_empty     = m_axis_tdata[23];
        seen_reply.out_of_range = m_axis_tdata[24];
        if (bitmap_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply: expected none, actual tdata 0x%h",
                   $time, m_axis_tdata);
        end else begin
          due_reply = bitmap_replies.pop_front();
          check_field("bit_value", due_reply.bit_value, seen_reply.bit_value);
          check_field("next_found", due_reply.next_found, seen_reply.next_found);
          check_field("next_index", due_reply.next_index, seen_reply.next_index);
          check_field("population", due_reply.population, seen_reply.population);
          check_field("is_empty", due_reply.is_empty, seen_reply.is_empty);
          check_field("out_of_range", due_reply.out_of_range, seen_reply.out_of_range);
        end
        delivered++;
        if (delivered % 100 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_gap = idle_len(rx_calm);
        // one long back-pressure stretch so the block fills and stalls its input
        if (!held_off && delivered == HoldAt) begin
          held_off = 1'b1;
          rx_gap   = HoldCycles;
        end
      end else if (rx_gap == 0 && !rx_calm && $urandom_range(0, 19) == 0) begin
        rx_gap = idle_len(1'b0);
      end
      if (rx_gap != 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    bitmap_req_t r;
    int unsigned p;
    int unsigned hot_base;
    // directed: edges, every code, out of range, empty and full searches
    add_req(FuncSet, 0);
    add_req(FuncSet, NBITS - 1);
    add_req(FuncSet, 0);                 // set twice, count unchanged
    add_req(FuncTest, 0);
    add_req(FuncTest, NBITS - 1);
    add_req(FuncFindNext, 0);
    add_req(FuncFindNext, 1);
    add_req(FuncFindNext, NBITS - 1);
    add_req(FuncTest, 5);
    add_req(FuncFindNext, NBITS);        // first index past the end
    add_req(FuncSet, 1023);
    add_req(FuncClear, 300);
    add_req(FuncTest, 512);
    add_req(3'd5, 3);                    // unknown codes act as a test
    add_req(3'd6, NBITS - 1);
    add_req(3'd7, 1023);
    add_req(FuncClear, 0);
    add_req(FuncFindNext, 0);
    add_req(FuncClear, NBITS - 1);
    add_req(FuncFindNext, 0);            // empty bitmap, nothing found
    add_req(FuncSet, 100);
    add_req(FuncSet, 101);
    add_req(FuncClearAll, 1023);         // index ignored
    add_req(FuncFindNext, 0);
    add_req(FuncClearAll, 0);

    // random: mostly in range, clustered so searches hit, some out of range
    hot_base = 0;
    for (int unsigned n = 0; n < RandomReqs; n++) begin
      if ($urandom_range(0, 39) == 0) hot_base = $urandom_range(0, NBITS - 32);
      p = $urandom_range(0, 99);
      if (p < 36)      r.func = FuncSet;
      else if (p < 56) r.func = FuncClear;
      else if (p < 70) r.func = FuncTest;
      else if (p < 95) r.func = FuncFindNext;
      else if (p < 96) r.func = FuncClearAll;
      else             r.func = FuncW'($urandom_range(5, 7));
      p = $urandom_range(0, 99);
      if (p < 10)      r.idx = BitIdxW'($urandom_range(NBITS, 1023));
      else if (p < 55) r.idx = BitIdxW'(hot_base + $urandom_range(0, 31));
      else if (p < 95) r.idx = BitIdxW'($urandom_range(0, NBITS - 1));
      else if (p < 97) r.idx = '0;
      else             r.idx = BitIdxW'(NBITS - 1);
      request_queue.push_back(r);
    end
    n_requests = request_queue.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted < n_requests || bitmap_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("bitmap_set_clear_find_next verification clean");
    end else begin
      $display("bitmap_set_clear_find_next verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("bitmap_set_clear_find_next verification failed");
    $finish;
  end

endmodule
